### design/cobs_frame_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// COBS frame decoder assertion macros
// Shared concurrent assertion forms for the decoder modules.
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_DECODER_UNIT_MACROS_SVH
`define COBS_FRAME_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfd assertion failed");

// next-cycle implication, disabled in reset
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfd assertion failed");

`endif

### design/cfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Item types, result codes and register map of the decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    localparam logic [0:0] REG_DECODED_CAPACITY = 1'b0;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_ZERO_CODE = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_CAPACITY  = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CODE_FULL_BLOCK = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic [15:0] decoded_length;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic        has_status;
        logic [1:0]  status;
        logic [15:0] length;
    } t_op;

endpackage
`default_nettype wire

### design/cfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// COBS frame decoder operation queue
// Small register FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`include "cobs_frame_decoder_unit_macros.svh"

module cfd_queue #(
    parameter int unsigned DEPTH = cfd_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire cfd_pkg::t_op i_op,
    input  wire logic         i_pop,
    output cfd_pkg::t_op      o_head,
    output logic              o_empty,
    output logic              o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cfd_pkg::t_op r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    logic l_push;
    logic l_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign l_push  = i_push && !o_full;
    assign l_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (l_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (l_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (l_push && !l_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (l_pop && !l_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    `CFD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `CFD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)

endmodule
`default_nettype wire

### design/cfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// COBS frame decoder front
// Accept encoded bytes, track block state and errors, queue emit operations.
// ----------------------------------------------------------------------------
`include "cobs_frame_decoder_unit_macros.svh"

module cfd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [15:0]       i_capacity,
    input  wire logic              i_in_valid,
    input  wire cfd_pkg::t_in_item i_in_item,
    output logic                   o_in_stall,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output cfd_pkg::t_op           o_op
);

    logic [7:0]  r_left,  n_left;
    logic        r_full,  n_full;
    logic        r_zpend, n_zpend;
    logic [15:0] r_count, n_count;
    logic [1:0]  r_err,   n_err;

    logic        l_fire;
    logic [7:0]  l_byte;
    logic [7:0]  l_byte_m1;
    logic [16:0] l_sum;
    logic        l_emit;
    logic [7:0]  l_emit_byte;
    logic [7:0]  l_left;
    logic        l_full;
    logic        l_zpend;
    logic [15:0] l_count;
    logic [1:0]  l_err;

    assign o_in_stall = i_q_full;
    assign l_fire     = i_in_valid && !i_q_full;
    assign l_byte     = i_in_item.data_byte;
    assign l_byte_m1  = l_byte - 8'd1;
    assign l_sum      = {1'b0, r_count} + (r_zpend ? {9'd0, l_byte} : {9'd0, l_byte_m1});

    always_comb begin
        l_emit      = 1'b0;
        l_emit_byte = 8'd0;
        l_left      = r_left;
        l_full      = r_full;
        l_zpend     = r_zpend;
        l_count     = r_count;
        l_err       = r_err;
        if (r_err == cfd_pkg::ERR_NONE) begin
            if (r_left == 8'd0) begin
                l_zpend = 1'b0;
                if (r_zpend && (r_count >= i_capacity)) begin
                    l_err = cfd_pkg::ERR_CAPACITY;
                end else begin
                    if (r_zpend) begin
                        l_emit  = 1'b1;
                        l_count = r_count + 16'd1;
                    end
                    if (l_byte == 8'd0) begin
                        l_err = cfd_pkg::ERR_ZERO_CODE;
                    end else if (l_sum > {1'b0, i_capacity}) begin
                        l_err = cfd_pkg::ERR_CAPACITY;
                    end else begin
                        l_left  = l_byte_m1;
                        l_full  = (l_byte == cfd_pkg::CODE_FULL_BLOCK);
                        l_zpend = (l_byte == 8'd1);
                    end
                end
            end else begin
                l_emit      = 1'b1;
                l_emit_byte = l_byte;
                l_count     = r_count + 16'd1;
                l_left      = r_left - 8'd1;
                if ((r_left == 8'd1) && !r_full) begin
                    l_zpend = 1'b1;
                end
            end
        end
        if (i_in_item.final_byte && (l_left != 8'd0) && (l_err == cfd_pkg::ERR_NONE)) begin
            l_err = cfd_pkg::ERR_TRUNCATED;
        end
    end

    always_comb begin
        o_op.has_data   = l_emit;
        o_op.data_byte  = l_emit_byte;
        o_op.has_status = i_in_item.final_byte;
        o_op.status     = l_err;
        o_op.length     = l_count;
        o_push          = l_fire && (l_emit || i_in_item.final_byte);

        n_left  = r_left;
        n_full  = r_full;
        n_zpend = r_zpend;
        n_count = r_count;
        n_err   = r_err;
        if (l_fire) begin
            if (i_in_item.final_byte) begin
                n_left  = 8'd0;
                n_full  = 1'b0;
                n_zpend = 1'b0;
                n_count = 16'd0;
                n_err   = cfd_pkg::ERR_NONE;
            end else begin
                n_left  = l_left;
                n_full  = l_full;
                n_zpend = l_zpend;
                n_count = l_count;
                n_err   = l_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 8'd0;
            r_full  <= 1'b0;
            r_zpend <= 1'b0;
            r_count <= 16'd0;
            r_err   <= cfd_pkg::ERR_NONE;
        end else begin
            r_left  <= n_left;
            r_full  <= n_full;
            r_zpend <= n_zpend;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    `CFD_ASSERT_NEXT(a_err_latched, i_clk, i_rst_n, (r_err != cfd_pkg::ERR_NONE) && !(l_fire && i_in_item.final_byte), r_err == $past(r_err))
    `CFD_ASSERT_NOW(a_err_no_emit, i_clk, i_rst_n, r_err != cfd_pkg::ERR_NONE, !l_emit)

endmodule
`default_nettype wire

### design/cfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// COBS frame decoder back
// Turn queued operations into data and status result items.
// ----------------------------------------------------------------------------
`include "cobs_frame_decoder_unit_macros.svh"

module cfd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cfd_pkg::t_op   i_op,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    output cfd_pkg::t_out_item  o_out_item,
    input  wire logic           i_out_stall
);

    logic               r_valid, n_valid;
    logic               r_sent,  n_sent;
    cfd_pkg::t_out_item r_item,  n_item;

    logic l_free;

    assign l_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_comb begin
        o_pop   = 1'b0;
        n_valid = r_valid && i_out_stall;
        n_sent  = r_sent;
        n_item  = r_item;
        if (l_free && !i_empty) begin
            n_valid = 1'b1;
            if (i_op.has_data && !r_sent) begin
                n_item.kind           = cfd_pkg::KIND_DATA;
                n_item.out_byte       = i_op.data_byte;
                n_item.status         = cfd_pkg::ERR_NONE;
                n_item.decoded_length = 16'd0;
                n_item.last_of_run    = !i_op.has_status;
                if (i_op.has_status) begin
                    n_sent = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_item.kind           = cfd_pkg::KIND_STATUS;
                n_item.out_byte       = 8'd0;
                n_item.status         = i_op.status;
                n_item.decoded_length = i_op.length;
                n_item.last_of_run    = 1'b1;
                n_sent                = 1'b0;
                o_pop                 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sent  <= n_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    `CFD_ASSERT_NOW(a_status_last, i_clk, i_rst_n, r_valid && (r_item.kind == cfd_pkg::KIND_STATUS), r_item.last_of_run && (r_item.out_byte == 8'd0))
    `CFD_ASSERT_NEXT(a_status_follows, i_clk, i_rst_n, r_valid && !i_out_stall && (r_item.kind == cfd_pkg::KIND_DATA) && !r_item.last_of_run, r_valid && (r_item.kind == cfd_pkg::KIND_STATUS))

endmodule
`default_nettype wire

### design/cobs_frame_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// COBS frame decoder unit
// Streaming decoder for byte-stuffed frames with length and error status.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle. Each byte yields at most one decoded
// byte; the final byte of a frame also yields a status item carrying the
// decoded length and the first error, so an item causes up to two results,
// emitted one after the other. A queue of QUEUE_DEPTH entries between the
// classifying front and the emitting back absorbs that and any output stall;
// the input stalls only while the queue is full. Operations are registered in
// the queue, results in the back's output register. Capacity is written over
// APB at byte addresses 0 to 3, reads back there and resets to 1024.
// ----------------------------------------------------------------------------

module cobs_frame_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = cfd_pkg::QUEUE_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire cfd_pkg::t_in_item               i_in_item,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output cfd_pkg::t_out_item                   o_out_item,
    input  wire logic                            i_out_stall,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [cfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cfd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    logic [15:0]  r_capacity, n_capacity;
    logic         l_sel_cap;
    logic         l_push;
    logic         l_pop;
    logic         l_empty;
    logic         l_full;
    cfd_pkg::t_op l_op_in;
    cfd_pkg::t_op l_op_head;

    assign pready    = 1'b1;
    assign l_sel_cap = (paddr[cfd_pkg::APB_ADDR_W-1:2] == cfd_pkg::REG_DECODED_CAPACITY);
    assign prdata    = l_sel_cap ? {16'd0, r_capacity} : '0;

    always_comb begin
        n_capacity = r_capacity;
        if (psel && penable && pwrite && l_sel_cap) begin
            n_capacity = pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= cfd_pkg::CAPACITY_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    cfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (l_full),
        .o_push     (l_push),
        .o_op       (l_op_in)
    );

    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (l_push),
        .i_op    (l_op_in),
        .i_pop   (l_pop),
        .o_head  (l_op_head),
        .o_empty (l_empty),
        .o_full  (l_full)
    );

    cfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (l_op_head),
        .i_empty     (l_empty),
        .o_pop       (l_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire
